// File: design/clx_pkg.sv
// Shared types, constants and byte classifiers for the C source lexer.
package clx_pkg;

  // Counter widths
  localparam int unsigned LINE_BITS   = 20;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned LENGTH_BITS = 16;

  // Token queue geometry
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  // Token kinds
  localparam logic [4:0] K_UNKNOWN = 5'd0;
  localparam logic [4:0] K_SLASH   = 5'd7;
  localparam logic [4:0] K_UNUSED  = 5'd11;
  localparam logic [4:0] K_IDENT   = 5'd24;
  localparam logic [4:0] K_STRING  = 5'd25;
  localparam logic [4:0] K_CHAR    = 5'd26;
  localparam logic [4:0] K_NUMBER  = 5'd27;
  localparam logic [4:0] K_END     = 5'd28;

  // Error codes
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_STRING = 2'd1;
  localparam logic [1:0] E_CHAR   = 2'd2;

  // Characters with a special role
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [4:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [OFFSET_BITS-1:0] offset;
    logic [LENGTH_BITS-1:0] length;
    logic [1:0]             err;
    logic                   last;
  } token_t;

  // Up to two tokens produced by one byte, packed from slot 0
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c inside {8'h20, 8'h09, 8'h0C, 8'h0B}) || is_nl(c);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Kind of a single-character punctuator, K_UNKNOWN when not one
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h7B: k = 5'd1;
      8'h7D: k = 5'd2;
      8'h28: k = 5'd3;
      8'h29: k = 5'd4;
      8'h5B: k = 5'd5;
      8'h5D: k = 5'd6;
      8'h2A: k = 5'd8;
      8'h3B: k = 5'd9;
      8'h3A: k = 5'd10;
      8'h3D: k = 5'd12;
      8'h2E: k = 5'd13;
      8'h2C: k = 5'd14;
      8'h3C: k = 5'd15;
      8'h3E: k = 5'd16;
      8'h2B: k = 5'd17;
      8'h2D: k = 5'd18;
      8'h21: k = 5'd19;
      8'h26: k = 5'd20;
      8'h7C: k = 5'd21;
      8'h7E: k = 5'd22;
      8'h3F: k = 5'd23;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// File: design/clx_core.sv
// Lexer state, position counters and per-byte token decision.
module clx_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      char_i,
  output clx_pkg::push_t  push_o
);
  import clx_pkg::*;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_IDENT     = 4'd1;
  localparam logic [3:0] M_NUMBER    = 4'd2;
  localparam logic [3:0] M_SLASH     = 4'd3;
  localparam logic [3:0] M_SKIPLINE  = 4'd4;
  localparam logic [3:0] M_BLOCK     = 4'd5;
  localparam logic [3:0] M_BLOCKSTAR = 4'd6;
  localparam logic [3:0] M_STRING    = 4'd7;
  localparam logic [3:0] M_STRESC    = 4'd8;
  localparam logic [3:0] M_CHAR      = 4'd9;
  localparam logic [3:0] M_CHRESC    = 4'd10;

  logic [3:0]             mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, line_inc;
  logic [COLUMN_BITS-1:0] col_q, col_d, col_inc;
  logic [OFFSET_BITS-1:0] off_q, off_d, off_inc;
  logic [LINE_BITS-1:0]   sline_q, sline_d;
  logic [COLUMN_BITS-1:0] scol_q, scol_d;
  logic [OFFSET_BITS-1:0] soff_q, soff_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;

  // Start-of-token decode for a byte seen with no token pending
  logic [3:0] st_mode;
  logic       st_begin;
  logic       st_emit;
  logic [4:0] st_kind;

  token_t     tok_a, tok_b;
  logic       a_vld, b_vld;

  // Saturating increments
  assign line_inc = (&line_q) ? line_q : line_q + LINE_BITS'(1);
  assign col_inc  = (&col_q)  ? col_q  : col_q + COLUMN_BITS'(1);
  assign off_inc  = (&off_q)  ? off_q  : off_q + OFFSET_BITS'(1);
  assign len_inc  = (&len_q)  ? len_q  : len_q + LENGTH_BITS'(1);

  // Classify a byte that opens a token
  always_comb begin
    st_mode  = M_IDLE;
    st_begin = 1'b0;
    st_emit  = 1'b0;
    st_kind  = K_UNKNOWN;
    if (is_ws(char_i)) begin
      st_emit = 1'b0;
    end else if (punct_kind(char_i) != K_UNKNOWN) begin
      st_emit = 1'b1;
      st_kind = punct_kind(char_i);
    end else if (char_i == CH_HASH) begin
      st_mode = M_SKIPLINE;
    end else if (char_i == CH_SLASH) begin
      st_mode  = M_SLASH;
      st_begin = 1'b1;
    end else if (char_i == CH_SQUOTE) begin
      st_mode  = M_CHAR;
      st_begin = 1'b1;
    end else if (char_i == CH_DQUOTE) begin
      st_mode  = M_STRING;
      st_begin = 1'b1;
    end else if (is_alpha(char_i) || char_i == CH_USCORE) begin
      st_mode  = M_IDENT;
      st_begin = 1'b1;
    end else if (is_dig(char_i)) begin
      st_mode  = M_NUMBER;
      st_begin = 1'b1;
    end else begin
      st_emit = 1'b1;
      st_kind = K_UNKNOWN;
    end
  end

  // Next state and the two token slots: pending token, then new or end token
  always_comb begin
    logic do_start;
    do_start = 1'b0;

    mode_d  = mode_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    soff_d  = soff_q;
    len_d   = len_q;

    a_vld        = 1'b0;
    tok_a.kind   = K_UNKNOWN;
    tok_a.line   = sline_q;
    tok_a.column = scol_q;
    tok_a.offset = soff_q;
    tok_a.length = len_q;
    tok_a.err    = E_NONE;
    tok_a.last   = 1'b0;

    b_vld        = 1'b0;
    tok_b.kind   = st_kind;
    tok_b.line   = line_q;
    tok_b.column = col_q;
    tok_b.offset = off_q;
    tok_b.length = LENGTH_BITS'(1);
    tok_b.err    = E_NONE;
    tok_b.last   = 1'b0;

    if (char_i == CH_NUL) begin
      // Flush pending token, then emit end and return to reset state
      case (mode_q)
        M_IDENT: begin
          a_vld = 1'b1;
          tok_a.kind = K_IDENT;
        end
        M_NUMBER: begin
          a_vld = 1'b1;
          tok_a.kind = K_NUMBER;
        end
        M_SLASH: begin
          a_vld = 1'b1;
          tok_a.kind = K_SLASH;
        end
        M_STRING, M_STRESC: begin
          a_vld = 1'b1;
          tok_a.kind = K_STRING;
          tok_a.err  = E_STRING;
        end
        M_CHAR, M_CHRESC: begin
          a_vld = 1'b1;
          tok_a.kind = K_CHAR;
          tok_a.err  = E_CHAR;
        end
        default: a_vld = 1'b0;
      endcase
      b_vld        = 1'b1;
      tok_b.kind   = K_END;
      tok_b.length = '0;
      mode_d  = M_IDLE;
      sline_d = LINE_BITS'(1);
      scol_d  = COLUMN_BITS'(1);
      soff_d  = '0;
      len_d   = '0;
    end else begin
      case (mode_q)
        M_IDENT: begin
          if (is_alpha(char_i) || is_dig(char_i) || char_i == CH_USCORE) begin
            len_d = len_inc;
          end else begin
            a_vld      = 1'b1;
            tok_a.kind = K_IDENT;
            do_start   = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_dig(char_i) || char_i == CH_DOT) begin
            len_d = len_inc;
          end else begin
            a_vld      = 1'b1;
            tok_a.kind = K_NUMBER;
            do_start   = 1'b1;
          end
        end
        M_SLASH: begin
          if (char_i == CH_SLASH) begin
            mode_d = M_SKIPLINE;
          end else if (char_i == CH_STAR) begin
            mode_d = M_BLOCK;
          end else begin
            a_vld      = 1'b1;
            tok_a.kind = K_SLASH;
            do_start   = 1'b1;
          end
        end
        M_SKIPLINE: begin
          if (is_nl(char_i)) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (char_i == CH_STAR) mode_d = M_BLOCKSTAR;
        end
        M_BLOCKSTAR: begin
          if (char_i == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (char_i != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_STRING: begin
          len_d = len_inc;
          if (char_i == CH_BSL) begin
            mode_d = M_STRESC;
          end else if (char_i == CH_DQUOTE) begin
            a_vld        = 1'b1;
            tok_a.kind   = K_STRING;
            tok_a.length = len_inc;
            mode_d       = M_IDLE;
          end
        end
        M_CHAR: begin
          len_d = len_inc;
          if (char_i == CH_BSL) begin
            mode_d = M_CHRESC;
          end else if (char_i == CH_SQUOTE) begin
            a_vld        = 1'b1;
            tok_a.kind   = K_CHAR;
            tok_a.length = len_inc;
            mode_d       = M_IDLE;
          end
        end
        M_STRESC: begin
          len_d  = len_inc;
          mode_d = M_STRING;
        end
        M_CHRESC: begin
          len_d  = len_inc;
          mode_d = M_CHAR;
        end
        default: do_start = 1'b1;
      endcase

      // Lex the byte as the first of a new token
      if (do_start) begin
        mode_d = st_mode;
        b_vld  = st_emit;
        if (st_begin) begin
          sline_d = line_q;
          scol_d  = col_q;
          soff_d  = off_q;
          len_d   = LENGTH_BITS'(1);
        end
      end
    end
  end

  // Advance the position counters
  always_comb begin
    if (char_i == CH_NUL) begin
      line_d = LINE_BITS'(1);
      col_d  = COLUMN_BITS'(1);
      off_d  = '0;
    end else begin
      line_d = is_nl(char_i) ? line_inc : line_q;
      col_d  = is_nl(char_i) ? COLUMN_BITS'(1) : col_inc;
      off_d  = off_inc;
    end
  end

  // Pack valid tokens from slot 0 and flag the final one
  always_comb begin
    push_o.tok0 = a_vld ? tok_a : tok_b;
    push_o.tok1 = tok_b;
    if (a_vld && b_vld) begin
      push_o.count     = 2'd2;
      push_o.tok1.last = 1'b1;
    end else begin
      push_o.count     = (a_vld || b_vld) ? 2'd1 : 2'd0;
      push_o.tok0.last = 1'b1;
    end
    if (!en_i) push_o.count = 2'd0;
  end

  // Hold state unless a byte is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= LINE_BITS'(1);
      col_q   <= COLUMN_BITS'(1);
      off_q   <= '0;
      sline_q <= LINE_BITS'(1);
      scol_q  <= COLUMN_BITS'(1);
      soff_q  <= '0;
      len_q   <= '0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      off_q   <= off_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      soff_q  <= soff_d;
      len_q   <= len_d;
    end
  end

endmodule

// File: design/clx_fifo.sv
// Token queue: takes up to two tokens a cycle, hands out one.
module clx_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clx_pkg::push_t  push_i,
  input  logic            pop_i,
  output clx_pkg::token_t head_o,
  output logic            empty_o,
  output logic            room_o
);
  import clx_pkg::*;

  token_t                mem_q [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_q, rd_q, wr_nxt;
  logic [QCNT_BITS-1:0]  cnt_q;

  assign wr_nxt  = wr_q + QPTR_BITS'(1);
  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  // Room for a worst-case pair of tokens
  assign room_o  = (cnt_q <= QCNT_BITS'(QDEPTH - 2));

  // Store pushed tokens
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.tok0;
    if (push_i.count == 2'd2) mem_q[wr_nxt] <= push_i.tok1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_BITS'(push_i.count);
      if (pop_i) rd_q <= rd_q + QPTR_BITS'(1);
      cnt_q <= cnt_q + QCNT_BITS'(push_i.count) - QCNT_BITS'(pop_i);
    end
  end

endmodule

// File: design/c_source_lexer.sv
// Top level of the streaming C source lexer.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_ready_o   char_in_i
//   result    out        out_valid_o/out_ready_i token_kind_o .. last_of_run_o
//
// A byte is registered on acceptance and lexed once the queue has room; its
// tokens (zero, one or two) then go into a four-entry token queue, and the
// first token is visible in the cycle after that. One byte per cycle is
// sustained while each byte yields at most one token and the output is ready;
// bytes yielding two tokens fill the queue faster than it drains. Bytes wait
// in the input register while the queue has fewer than two free entries.
// Reset returns the lexer to line 1, column 1, offset 0 and empties the queue.
module c_source_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [clx_pkg::LINE_BITS-1:0]   start_line_o,
  output logic [clx_pkg::COLUMN_BITS-1:0] start_column_o,
  output logic [clx_pkg::OFFSET_BITS-1:0] start_offset_o,
  output logic [clx_pkg::LENGTH_BITS-1:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);
  import clx_pkg::*;

  logic       byte_vld_q;
  logic [7:0] byte_q;
  logic       room, empty, proc;
  push_t      push;
  token_t     head;

  assign proc       = byte_vld_q && room;
  assign in_ready_o = !byte_vld_q || room;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) byte_q <= char_in_i;
  end

  clx_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc),
    .char_i (byte_q),
    .push_o (push)
  );

  clx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .head_o  (head),
    .empty_o (empty),
    .room_o  (room)
  );

  // Drive result ports from the queue head
  assign out_valid_o    = !empty;
  assign token_kind_o   = head.kind;
  assign start_line_o   = head.line;
  assign start_column_o = head.column;
  assign start_offset_o = head.offset;
  assign token_length_o = head.length;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.last;

endmodule

// File: design/clx_checker.sv
// Port-level checks for the C source lexer, bound to the top level.
module clx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_o,
  input logic [clx_pkg::LENGTH_BITS-1:0] token_length_o,
  input logic [1:0]  error_code_o,
  input logic        last_of_run_o
);
  import clx_pkg::*;

  // A stalled transaction holds its kind, length and last flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o)
      && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("result transaction changed while stalled");

  // End token closes its run with zero length and no error
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_END |->
      last_of_run_o && token_length_o == '0 && error_code_o == E_NONE)
    else $error("malformed end token");

  // Only an unterminated literal carries an error, and the end token follows it
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != E_NONE |->
      !last_of_run_o && ((error_code_o == E_STRING && token_kind_o == K_STRING) ||
                         (error_code_o == E_CHAR && token_kind_o == K_CHAR)))
    else $error("error code on wrong token");

  // No unused or out-of-range kind
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o != K_UNUSED && token_kind_o <= K_END)
    else $error("invalid token kind");

endmodule

bind c_source_lexer clx_checker u_clx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .token_length_o (token_length_o),
  .error_code_o   (error_code_o),
  .last_of_run_o  (last_of_run_o)
);
